[rtl/otsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Otsu threshold engine package
// Shared widths, constants, state and operation codes, and control structs.
// ----------------------------------------------------------------------------
package otsu_pkg;

  // Frame size limit and derived widths.
  localparam int MAX_FRAME_PIXELS = 16384;
  localparam int CNT_W   = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int GRAY_W  = 8;
  localparam int BINS    = 256;
  localparam int BIN_W   = $clog2(BINS);
  localparam int SUM_W   = CNT_W + GRAY_W;
  localparam int N_W     = CNT_W + SUM_W;
  localparam int D_W     = 2 * CNT_W;
  localparam int MA_W    = 2 * N_W;
  localparam int MB_W    = N_W;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int DIG_W   = 8;
  localparam int MUL_STEPS = (MB_W + DIG_W - 1) / DIG_W;
  localparam int STEP_W  = $clog2(MUL_STEPS + 1);
  localparam int PC_W    = 15;

  // RGB565 channel masks and the divide-by-three reciprocal (x * 683 >> 11).
  localparam logic [4:0]  R5_MASK  = 5'h1F;
  localparam logic [5:0]  G6_MASK  = 6'h3F;
  localparam int          RGB_W    = 10;
  localparam int          RPROD_W  = 21;
  localparam logic [10:0] RECIP3   = 11'd683;
  localparam int          RSHIFT   = 11;

  // Input format register codes.
  localparam logic FMT_GRAY   = 1'b0;
  localparam logic FMT_RGB565 = 1'b1;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_SINIT,
    ST_SRD,
    ST_SACC,
    ST_MGO,
    ST_MWAIT,
    ST_CMP,
    ST_EMIT
  } state_e;

  // Multiply operations of one scan step, in issue order.
  typedef enum logic [2:0] {
    OP_TSB,
    OP_WSA,
    OP_D,
    OP_N2,
    OP_LHS,
    OP_RHS
  } mul_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    inc_we;
    logic    clr_we;
    logic    idx_inc;
    logic    scan_init;
    logic    acc;
    logic    mul_start;
    logic    mul_latch;
    mul_op_e mul_op;
    logic    cmp;
    logic    emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic last;
    logic wb_zero;
    logic wb_full;
    logic idx_last;
    logic mul_done;
  } dp_status_t;

endpackage

[rtl/otsu_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module otsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/otsu_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative multiplier
// Multiplies a wide operand by one 8-bit digit of the other operand per cycle.
// ----------------------------------------------------------------------------
module otsu_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [otsu_pkg::MA_W-1:0]   a_i,
  input  logic [otsu_pkg::MB_W-1:0]   b_i,
  output logic                        done_o,
  output logic [otsu_pkg::PROD_W-1:0] prod_o
);

  logic [otsu_pkg::PROD_W-1:0] a_q, a_d;
  logic [otsu_pkg::MUL_STEPS*otsu_pkg::DIG_W-1:0] b_q, b_d;
  logic [otsu_pkg::PROD_W-1:0] acc_q, acc_d;
  logic [otsu_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic run_q, run_d;
  logic done_q, done_d;

  // Shift-and-add over the digits of the second operand.
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d   = otsu_pkg::PROD_W'(a_i);
      b_d   = (otsu_pkg::MUL_STEPS*otsu_pkg::DIG_W)'(b_i);
      acc_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      acc_d = acc_q + a_q * otsu_pkg::PROD_W'(b_q[otsu_pkg::DIG_W-1:0]);
      a_d   = a_q << otsu_pkg::DIG_W;
      b_d   = b_q >> otsu_pkg::DIG_W;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == otsu_pkg::STEP_W'(otsu_pkg::MUL_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[rtl/otsu_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Otsu datapath
// Gray conversion, histogram memory, frame counters, scan accumulators,
// variance products, best-threshold tracking and result registers.
// ----------------------------------------------------------------------------
module otsu_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic [15:0]                pixel_i,
  input  logic                       last_i,
  input  otsu_pkg::ctrl_cmd_t        cmd_i,
  output otsu_pkg::dp_status_t       status_o,
  output logic                       valid_o,
  output logic [7:0]                 threshold_o,
  output logic [otsu_pkg::PC_W-1:0]  pixel_count_o,
  output logic                       overflow_o
);

  logic                          fmt_q;
  logic [otsu_pkg::GRAY_W-1:0]   gray_c, gray_q;
  logic                          last_q;
  logic [otsu_pkg::CNT_W-1:0]    cnt_q;
  logic [otsu_pkg::SUM_W-1:0]    sum_all_q;
  logic                          ovf_q;
  logic [otsu_pkg::BIN_W-1:0]    idx_q;
  logic [otsu_pkg::CNT_W-1:0]    wb_q;
  logic [otsu_pkg::SUM_W-1:0]    sb_q;
  logic [otsu_pkg::CNT_W:0]      wb_new;
  logic [otsu_pkg::N_W-1:0]      ta_q, n_q, p_low;
  logic [otsu_pkg::D_W-1:0]      d_q, bd_q;
  logic [otsu_pkg::MA_W-1:0]     n2_q, bn2_q;
  logic [otsu_pkg::PROD_W-1:0]   lhs_q, rhs_q;
  logic [otsu_pkg::GRAY_W-1:0]   bt_q;
  logic                          valid_q, ovfo_q;
  logic [7:0]                    thr_q;
  logic [otsu_pkg::PC_W-1:0]     pc_q;
  logic [otsu_pkg::RGB_W-1:0]    rgb_sum;
  logic [otsu_pkg::RPROD_W-1:0]  rgb_prod;
  logic [otsu_pkg::CNT_W-1:0]    ram_rdata, ram_wdata;
  logic [otsu_pkg::BIN_W-1:0]    ram_raddr, ram_waddr;
  logic                          ram_we;
  logic [otsu_pkg::MA_W-1:0]     mul_a;
  logic [otsu_pkg::MB_W-1:0]     mul_b;
  logic                          mul_done;
  logic [otsu_pkg::PROD_W-1:0]   mul_p;

  // Gray conversion: low byte, or RGB565 channels widened and divided by three.
  always_comb begin
    rgb_sum = otsu_pkg::RGB_W'({pixel_i[15:11] & otsu_pkg::R5_MASK, 3'b000})
            + otsu_pkg::RGB_W'({pixel_i[10:5] & otsu_pkg::G6_MASK, 2'b00})
            + otsu_pkg::RGB_W'({pixel_i[4:0] & otsu_pkg::R5_MASK, 3'b000});
    rgb_prod = otsu_pkg::RPROD_W'(rgb_sum) * otsu_pkg::RPROD_W'(otsu_pkg::RECIP3);
    if (fmt_q == otsu_pkg::FMT_RGB565) begin
      gray_c = otsu_pkg::GRAY_W'(rgb_prod >> otsu_pkg::RSHIFT);
    end else begin
      gray_c = pixel_i[7:0];
    end
  end

  // Histogram memory ports.
  assign ram_raddr = cmd_i.accept ? gray_c : idx_q;
  assign ram_we    = cmd_i.inc_we | cmd_i.clr_we;
  assign ram_waddr = cmd_i.inc_we ? gray_q : idx_q;
  assign ram_wdata = cmd_i.inc_we ? ram_rdata + 1'b1 : '0;

  otsu_ram #(
    .WIDTH (otsu_pkg::CNT_W),
    .DEPTH (otsu_pkg::BINS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_op)
      otsu_pkg::OP_TSB: begin
        mul_a = otsu_pkg::MA_W'(cnt_q);
        mul_b = otsu_pkg::MB_W'(sb_q);
      end
      otsu_pkg::OP_WSA: begin
        mul_a = otsu_pkg::MA_W'(wb_q);
        mul_b = otsu_pkg::MB_W'(sum_all_q);
      end
      otsu_pkg::OP_D: begin
        mul_a = otsu_pkg::MA_W'(wb_q);
        mul_b = otsu_pkg::MB_W'(cnt_q - wb_q);
      end
      otsu_pkg::OP_N2: begin
        mul_a = otsu_pkg::MA_W'(n_q);
        mul_b = n_q;
      end
      otsu_pkg::OP_LHS: begin
        mul_a = n2_q;
        mul_b = otsu_pkg::MB_W'(bd_q);
      end
      otsu_pkg::OP_RHS: begin
        mul_a = bn2_q;
        mul_b = otsu_pkg::MB_W'(d_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  otsu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  assign p_low  = otsu_pkg::N_W'(mul_p);
  assign wb_new = otsu_pkg::CNT_W'(wb_q) + (otsu_pkg::CNT_W + 1)'(ram_rdata);

  // Control state: format register, frame counters, bin index, result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= otsu_pkg::FMT_GRAY;
      cnt_q     <= '0;
      sum_all_q <= '0;
      ovf_q     <= 1'b0;
      idx_q     <= '0;
      last_q    <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        last_q <= last_i;
        if (status_o.full) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q     <= cnt_q + 1'b1;
          sum_all_q <= sum_all_q + otsu_pkg::SUM_W'(gray_c);
        end
      end
      // The scan may stop early, so the clearing pass restarts from bin zero.
      if (cmd_i.scan_init || cmd_i.emit) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      valid_q <= cmd_i.emit;
      if (cmd_i.emit) begin
        cnt_q     <= '0;
        sum_all_q <= '0;
        ovf_q     <= 1'b0;
      end
    end
  end

  // Scan accumulators, products and best candidate.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      gray_q <= gray_c;
    end
    if (cmd_i.scan_init) begin
      wb_q  <= '0;
      sb_q  <= '0;
      bn2_q <= '0;
      bd_q  <= otsu_pkg::D_W'(1);
      bt_q  <= '0;
    end
    if (cmd_i.acc) begin
      wb_q <= otsu_pkg::CNT_W'(wb_new);
      sb_q <= sb_q + otsu_pkg::SUM_W'(idx_q) * otsu_pkg::SUM_W'(ram_rdata);
    end
    if (cmd_i.mul_latch) begin
      unique case (cmd_i.mul_op)
        otsu_pkg::OP_TSB: ta_q  <= p_low;
        otsu_pkg::OP_WSA: n_q   <= (ta_q >= p_low) ? ta_q - p_low : p_low - ta_q;
        otsu_pkg::OP_D:   d_q   <= otsu_pkg::D_W'(mul_p);
        otsu_pkg::OP_N2:  n2_q  <= otsu_pkg::MA_W'(mul_p);
        otsu_pkg::OP_LHS: lhs_q <= mul_p;
        otsu_pkg::OP_RHS: rhs_q <= mul_p;
        default: ;
      endcase
    end
    if (cmd_i.cmp && (lhs_q > rhs_q)) begin
      bn2_q <= n2_q;
      bd_q  <= d_q;
      bt_q  <= idx_q;
    end
    if (cmd_i.emit) begin
      thr_q  <= bt_q;
      pc_q   <= otsu_pkg::PC_W'(cnt_q);
      ovfo_q <= ovf_q;
    end
  end

  // Status back to the controller.
  always_comb begin
    status_o.full     = (cnt_q == otsu_pkg::CNT_W'(otsu_pkg::MAX_FRAME_PIXELS));
    status_o.last     = last_q;
    status_o.wb_zero  = (wb_new == '0);
    status_o.wb_full  = (wb_new >= (otsu_pkg::CNT_W + 1)'(cnt_q));
    status_o.idx_last = (idx_q == otsu_pkg::BIN_W'(otsu_pkg::BINS - 1));
    status_o.mul_done = mul_done;
  end

  assign valid_o       = valid_q;
  assign threshold_o   = thr_q;
  assign pixel_count_o = pc_q;
  assign overflow_o    = ovfo_q;

endmodule

[rtl/otsu_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Otsu controller
// Sequences histogram clearing, pixel counting, the threshold scan and output.
// ----------------------------------------------------------------------------
module otsu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 last_i,
  input  otsu_pkg::dp_status_t status_i,
  output otsu_pkg::ctrl_cmd_t  cmd_o,
  output logic                 busy_o
);

  otsu_pkg::state_e  state_q, state_d;
  otsu_pkg::mul_op_e op_q, op_d;

  // Next state and multiply operation.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      otsu_pkg::ST_CLEAR: begin
        if (status_i.idx_last) state_d = otsu_pkg::ST_IDLE;
      end
      otsu_pkg::ST_IDLE: begin
        if (start_i) begin
          if (!status_i.full) state_d = otsu_pkg::ST_INC;
          else if (last_i)    state_d = otsu_pkg::ST_SINIT;
        end
      end
      otsu_pkg::ST_INC: begin
        state_d = status_i.last ? otsu_pkg::ST_SINIT : otsu_pkg::ST_IDLE;
      end
      otsu_pkg::ST_SINIT: state_d = otsu_pkg::ST_SRD;
      otsu_pkg::ST_SRD:   state_d = otsu_pkg::ST_SACC;
      otsu_pkg::ST_SACC: begin
        if (status_i.wb_zero) begin
          state_d = status_i.idx_last ? otsu_pkg::ST_EMIT : otsu_pkg::ST_SRD;
        end else if (status_i.wb_full) begin
          state_d = otsu_pkg::ST_EMIT;
        end else begin
          op_d    = otsu_pkg::OP_TSB;
          state_d = otsu_pkg::ST_MGO;
        end
      end
      otsu_pkg::ST_MGO: state_d = otsu_pkg::ST_MWAIT;
      otsu_pkg::ST_MWAIT: begin
        if (status_i.mul_done) begin
          state_d = otsu_pkg::ST_MGO;
          unique case (op_q)
            otsu_pkg::OP_TSB: op_d = otsu_pkg::OP_WSA;
            otsu_pkg::OP_WSA: op_d = otsu_pkg::OP_D;
            otsu_pkg::OP_D:   op_d = otsu_pkg::OP_N2;
            otsu_pkg::OP_N2:  op_d = otsu_pkg::OP_LHS;
            otsu_pkg::OP_LHS: op_d = otsu_pkg::OP_RHS;
            default:          state_d = otsu_pkg::ST_CMP;
          endcase
        end
      end
      otsu_pkg::ST_CMP: begin
        state_d = status_i.idx_last ? otsu_pkg::ST_EMIT : otsu_pkg::ST_SRD;
      end
      otsu_pkg::ST_EMIT: state_d = otsu_pkg::ST_CLEAR;
      default:           state_d = otsu_pkg::ST_CLEAR;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o        = '0;
    cmd_o.mul_op = op_q;
    unique case (state_q)
      otsu_pkg::ST_CLEAR: begin
        cmd_o.clr_we  = 1'b1;
        cmd_o.idx_inc = 1'b1;
      end
      otsu_pkg::ST_IDLE:  cmd_o.accept    = start_i;
      otsu_pkg::ST_INC:   cmd_o.inc_we    = 1'b1;
      otsu_pkg::ST_SINIT: cmd_o.scan_init = 1'b1;
      otsu_pkg::ST_SRD:   ;
      otsu_pkg::ST_SACC: begin
        cmd_o.acc     = 1'b1;
        cmd_o.idx_inc = status_i.wb_zero && !status_i.idx_last;
      end
      otsu_pkg::ST_MGO:   cmd_o.mul_start = 1'b1;
      otsu_pkg::ST_MWAIT: cmd_o.mul_latch = status_i.mul_done;
      otsu_pkg::ST_CMP: begin
        cmd_o.cmp     = 1'b1;
        cmd_o.idx_inc = !status_i.idx_last;
      end
      otsu_pkg::ST_EMIT:  cmd_o.emit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= otsu_pkg::ST_CLEAR;
      op_q    <= otsu_pkg::OP_TSB;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign busy_o = (state_q != otsu_pkg::ST_IDLE);

endmodule

[rtl/otsu_threshold_engine_top.sv]
`timescale 1ns / 1ps
// A counted pixel takes a memory read and then an increment; a pixel dropped on a
// full frame is not written. The last pixel starts a scan of up to 256 bins: bins
// before the first filled one are only read, each later bin forms six products on
// one 8-bit-digit multiplier; then follow one result strobe and a histogram clear.
// After reset the block is busy for the same clearing pass over all 256 bins.
// The result is shown for one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// Otsu threshold engine
// Counts a frame of gray or RGB565 pixels into a histogram and emits its Otsu
// threshold, pixel count and overflow flag when the last pixel arrives.
// ----------------------------------------------------------------------------
module otsu_threshold_engine_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [15:0]               pixel_i,
  input  logic                      last_i,
  output logic                      valid_o,
  output logic [7:0]                threshold_o,
  output logic [otsu_pkg::PC_W-1:0] pixel_count_o,
  output logic                      overflow_o
);

  otsu_pkg::ctrl_cmd_t  cmd;
  otsu_pkg::dp_status_t status;

  // Controller.
  otsu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .last_i   (last_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Datapath.
  otsu_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pixel_i       (pixel_i),
    .last_i        (last_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .valid_o       (valid_o),
    .threshold_o   (threshold_o),
    .pixel_count_o (pixel_count_o),
    .overflow_o    (overflow_o)
  );

  // A result strobe lasts one cycle and falls in the clearing pass.
  a_valid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o) else $error("result shown while idle");

  // A counted pixel always takes the increment cycle.
  a_inc_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !status.full) |=> (busy_o && cmd.inc_we))
    else $error("counted pixel not incremented");

  // The multiplier only finishes while the controller waits on it.
  a_mul_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.mul_done |-> (busy_o && !cmd.mul_start))
    else $error("multiplier done outside a wait");

endmodule
